@@ rtl/pva_pkg.sv @@
`timescale 1ns / 1ps
package pva_pkg;

  localparam int CHIPS_DEF    = 3;
  localparam int VPC_DEF      = 3;
  localparam int CHANNELS_DEF = 9;

  // The chip map register holds two bits for each of this many channels.
  localparam int MAP_CHANNELS = 9;
  localparam int MAX_RESULTS  = 9;
  localparam int LIST_W       = 4;
  localparam int UNISON_WIDTH = 3;
  localparam int STEAL_LIMIT  = 16;
  localparam int HOLD_W       = 9;

  localparam logic [1:0]  MODE_SEMI = 2'd0;
  localparam logic [1:0]  MODE_FULL = 2'd1;
  localparam logic [1:0]  MODE_MONO = 2'd2;
  localparam logic [17:0] MAP_RESET = 18'd173376;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_TRIGGER = 3'd1,
    ACT_MARK    = 3'd2,
    ACT_HOLD    = 3'd3,
    ACT_STOP    = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    CFG_POLY_MODE    = 3'd0,
    CFG_UNISON_MODE  = 3'd1,
    CFG_LINK_MASK    = 3'd2,
    CFG_LINK_CHIPS   = 3'd3,
    CFG_FX_RESERVE   = 3'd4,
    CFG_CHIP_MAP     = 3'd5,
    CFG_RELEASE_HOLD = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]        poly_mode;
    logic              unison_mode;
    logic [2:0]        link_voice_mask;
    logic [1:0]        link_chips;
    logic              fx_reserve;
    logic [17:0]       channel_chip_map;
    logic [HOLD_W-1:0] release_hold_mask;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] voice;
    action_t    act;
  } res_wr_t;

endpackage

@@ rtl/pva_in_if.sv @@
`timescale 1ns / 1ps
interface pva_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [3:0] channel;
  logic [6:0] note;
  logic       sustain_held;

  modport source (output valid, opcode, channel, note, sustain_held, input ready);
  modport sink (input valid, opcode, channel, note, sustain_held, output ready);
endinterface

@@ rtl/pva_out_if.sv @@
`timescale 1ns / 1ps
interface pva_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] voice_index;
  logic [2:0] action;
  logic       last;

  modport source (output valid, voice_index, action, last, input ready);
  modport sink (input valid, voice_index, action, last, output ready);
endinterface

@@ rtl/pva_cfg_if.sv @@
`timescale 1ns / 1ps
interface pva_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [17:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/pva_cfg_regs.sv @@
`timescale 1ns / 1ps
module pva_cfg_regs import pva_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr_valid,
  output logic        wr_ready,
  input  logic [2:0]  wr_index,
  input  logic [17:0] wr_data,
  output cfg_t        cfg_q
);

  cfg_t cfg_r;

  assign wr_ready = 1'b1;
  assign cfg_q    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.poly_mode         <= MODE_FULL;
      cfg_r.unison_mode       <= 1'b0;
      cfg_r.link_voice_mask   <= 3'd0;
      cfg_r.link_chips        <= 2'd0;
      cfg_r.fx_reserve        <= 1'b0;
      cfg_r.channel_chip_map  <= MAP_RESET;
      cfg_r.release_hold_mask <= '0;
    end else if (wr_valid) begin
      case (cfg_idx_t'(wr_index))
        CFG_POLY_MODE:    cfg_r.poly_mode         <= wr_data[1:0];
        CFG_UNISON_MODE:  cfg_r.unison_mode       <= wr_data[0];
        CFG_LINK_MASK:    cfg_r.link_voice_mask   <= wr_data[2:0];
        CFG_LINK_CHIPS:   cfg_r.link_chips        <= wr_data[1:0];
        CFG_FX_RESERVE:   cfg_r.fx_reserve        <= wr_data[0];
        CFG_CHIP_MAP:     cfg_r.channel_chip_map  <= wr_data;
        CFG_RELEASE_HOLD: cfg_r.release_hold_mask <= wr_data[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/pva_emit.sv @@
`timescale 1ns / 1ps
module pva_emit import pva_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  res_wr_t    res_wr,
  input  logic       flush,
  output logic       busy,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] out_voice_index,
  output logic [2:0] out_action,
  output logic       out_last
);

  logic [3:0]        lv_r [MAX_RESULTS];
  action_t           la_r [MAX_RESULTS];
  logic [LIST_W-1:0] cnt_r;
  logic [LIST_W-1:0] rd_r;
  logic              drain_r;
  logic              ov_r;
  logic [3:0]        ovi_r;
  action_t           oa_r;
  logic              olast_r;
  logic              load;
  logic              is_last;

  assign load    = drain_r && (!ov_r || out_ready);
  assign is_last = (cnt_r == '0) || (rd_r == cnt_r - LIST_W'(1));
  assign busy    = drain_r;

  assign out_valid       = ov_r;
  assign out_voice_index = ovi_r;
  assign out_action      = oa_r;
  assign out_last        = olast_r;

  always_ff @(posedge clk) begin
    if (res_wr.valid && cnt_r < LIST_W'(MAX_RESULTS)) begin
      lv_r[cnt_r] <= res_wr.voice;
      la_r[cnt_r] <= res_wr.act;
    end
    if (load) begin
      // An item that touched no voice still gets one beat.
      ovi_r   <= (cnt_r == '0) ? 4'd0 : lv_r[rd_r];
      oa_r    <= (cnt_r == '0) ? ACT_NONE : la_r[rd_r];
      olast_r <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      rd_r    <= '0;
      drain_r <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      if (res_wr.valid && cnt_r < LIST_W'(MAX_RESULTS)) begin
        cnt_r <= cnt_r + LIST_W'(1);
      end
      if (flush) begin
        drain_r <= 1'b1;
        rd_r    <= '0;
      end
      if (load) begin
        ov_r <= 1'b1;
        if (is_last) begin
          drain_r <= 1'b0;
          cnt_r   <= '0;
        end else begin
          rd_r <= rd_r + LIST_W'(1);
        end
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/pva_core.sv @@
`timescale 1ns / 1ps
module pva_core import pva_pkg::*; #(
  parameter int CHIPS           = CHIPS_DEF,
  parameter int VOICES_PER_CHIP = VPC_DEF,
  parameter int CHANNELS        = CHANNELS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg_q,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_opcode,
  input  logic [3:0] in_channel,
  input  logic [6:0] in_note,
  input  logic       in_sustain,
  output res_wr_t    res_wr,
  output logic       flush,
  input  logic       emit_busy
);

  localparam int VPC  = VOICES_PER_CHIP;
  localparam int NV   = CHIPS * VPC;
  localparam int IW   = (NV > 1) ? $clog2(NV) : 1;
  localparam int VW   = (VPC > 1) ? $clog2(VPC) : 1;
  localparam int CW   = (CHIPS > 1) ? $clog2(CHIPS) : 1;
  localparam int WANT = (NV < UNISON_WIDTH) ? NV : UNISON_WIDTH;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_SCAN   = 10'b0000000010,
    S_DECIDE = 10'b0000000100,
    S_ACT    = 10'b0000001000,
    S_UOCC   = 10'b0000010000,
    S_USTEAL = 10'b0000100000,
    S_PSTEAL = 10'b0001000000,
    S_OFF    = 10'b0010000000,
    S_FLUSH  = 10'b0100000000,
    S_WAIT   = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  // Event
  logic          op_r, sus_r;
  logic [3:0]    ch_r;
  logic [6:0]    note_r;
  logic [1:0]    c_ev_r;

  // Scan position
  logic [IW-1:0] idx_r;
  logic [1:0]    sc_r;
  logic [VW-1:0] sv_r;

  // Scan findings
  logic          has_m_r, has_f_r;
  logic [IW-1:0] m_idx_r, f_idx_r;
  logic [IW-1:0] ul_r [UNISON_WIDTH];
  logic [IW-1:0] uf_r [UNISON_WIDTH];
  logic [IW-1:0] ol_r [UNISON_WIDTH];
  logic [1:0]    un_r, ufn_r, on_r, j_r;
  logic [NV-1:0] mvec_r, fmask_r;

  // Activation target
  logic [1:0]     tgt_c_r;
  logic [VW-1:0]  k_r;
  logic [VPC-1:0] am_r;
  logic           extra_en_r, l0hit_r;

  // Steal pointers and voice state
  logic [IW-1:0]  pptr_r, pstart_r, uptr_r;
  logic [3:0]     step_r;
  logic [VW-1:0]  cptr_r [CHIPS];
  logic           busy_r [NV];
  logic [6:0]     vnote_r [NV];
  logic [3:0]     owner_r [NV];

  function automatic logic [3:0] quo_f(input logic [3:0] p);
    logic [3:0] q;
    q = '0;
    for (int k = 1; k < 16; k++) begin
      if (7'(k * VPC) <= {3'b000, p}) q = 4'(k);
    end
    return q;
  endfunction

  function automatic logic [3:0] rem_f(input logic [3:0] p);
    logic [3:0] q;
    q = quo_f(p);
    return 4'(p - 4'(q * VPC));
  endfunction

  function automatic logic [1:0] chip_of_f(input logic [3:0] ch);
    logic [1:0] c;
    c = '0;
    for (int k = 0; k < MAP_CHANNELS; k++) begin
      if (ch == 4'(k)) c = cfg_q.channel_chip_map[2*k +: 2];
    end
    return c;
  endfunction

  function automatic logic [VPC-1:0] allowed_f(input logic [1:0] c);
    logic [VPC-1:0] lm;
    lm = VPC'(cfg_q.link_voice_mask);
    if (cfg_q.link_voice_mask == 3'd0) return '1;
    if (c == 2'd0) return lm;
    if (c == 2'd1 && cfg_q.link_chips[0]) return lm;
    if (c == 2'd2 && cfg_q.link_chips[1]) return lm;
    return '1;
  endfunction

  // A linked voice brings along all linked voices of its chip.
  function automatic logic [VPC-1:0] am_f(input logic [VW-1:0] v);
    logic [VPC-1:0] lm;
    lm = VPC'(cfg_q.link_voice_mask);
    return lm[v] ? lm : (VPC'(1) << v);
  endfunction

  // Mode decode
  logic          uni, is_mono, is_full, is_semi, ign;
  logic [2:0]    maxc;
  logic [4:0]    maxv;
  logic [VPC-1:0] lm_v;
  logic [NV-1:0] hold_v;

  assign uni     = cfg_q.unison_mode;
  assign is_mono = !uni && cfg_q.poly_mode == MODE_MONO;
  assign is_full = !uni && cfg_q.poly_mode == MODE_FULL;
  assign is_semi = !uni && !is_mono && !is_full;
  assign maxc    = (cfg_q.fx_reserve && CHIPS > 1) ? 3'(CHIPS - 1) : 3'(CHIPS);
  assign maxv    = 5'({2'b00, maxc} * 5'(VPC));
  assign lm_v    = VPC'(cfg_q.link_voice_mask);
  assign hold_v  = NV'(cfg_q.release_hold_mask);
  assign ign     = ({1'b0, ch_r} >= 5'(CHANNELS)) || (is_full && ch_r != 4'd0) ||
                   ((is_mono || is_semi) && {1'b0, c_ev_r} >= 3'(CHIPS));

  // Current voice at the scan position
  logic           cur_busy, cur_match, cur_alw, scope;
  logic [VPC-1:0] alw_row;

  assign alw_row   = allowed_f(sc_r);
  assign cur_alw   = alw_row[sv_r];
  assign cur_busy  = busy_r[idx_r];
  assign cur_match = cur_busy && owner_r[idx_r] == ch_r && vnote_r[idx_r] == note_r;
  assign scope     = is_full ? ({1'b0, sc_r} < maxc) : (sc_r == c_ev_r);

  // Decision
  logic [3:0]     vm4;
  logic [VW-1:0]  vm;
  logic [VPC-1:0] a_ev;
  logic [3:0]     tsel_q, tsel_r4;
  logic           sf_found;
  logic [VW-1:0]  sf_v, sf_walk;

  assign vm4     = rem_f(ch_r);
  assign vm      = VW'(vm4);
  assign a_ev    = allowed_f(c_ev_r);
  assign tsel_q  = quo_f(4'(has_m_r ? m_idx_r : f_idx_r));
  assign tsel_r4 = rem_f(4'(has_m_r ? m_idx_r : f_idx_r));

  always_comb begin
    sf_found = 1'b0;
    sf_v     = '0;
    sf_walk  = cptr_r[c_ev_r[CW-1:0]];
    for (int s = 0; s < VPC; s++) begin
      if (!sf_found && a_ev[sf_walk]) begin
        sf_found = 1'b1;
        sf_v     = sf_walk;
      end
      sf_walk = (sf_walk == VW'(VPC - 1)) ? '0 : sf_walk + VW'(1);
    end
  end

  // Poly steal step
  logic [3:0]     ps_c4, ps_v4;
  logic [VPC-1:0] ps_row;
  logic           ps_ok;
  logic [4:0]     ps_t0, ps_t1, ps_t2;
  logic [IW-1:0]  ps_next;

  assign ps_c4   = quo_f(4'(pptr_r));
  assign ps_v4   = rem_f(4'(pptr_r));
  assign ps_row  = allowed_f(2'(ps_c4));
  assign ps_ok   = ({1'b0, ps_c4} < {2'b00, maxc}) && ps_row[VW'(ps_v4)];
  assign ps_t0   = 5'(pptr_r) + 5'd1;
  assign ps_t1   = (ps_t0 >= maxv) ? ps_t0 - maxv : ps_t0;
  assign ps_t2   = (ps_t1 >= maxv) ? ps_t1 - maxv : ps_t1;
  assign ps_next = IW'(ps_t2);

  // Release pass
  logic    off_hit, off_extra;
  action_t off_act;

  assign off_hit = is_mono ? (sc_r == c_ev_r && am_r[sv_r] && mvec_r[idx_r]) :
                   (is_full || uni) ? mvec_r[idx_r] : (sc_r == c_ev_r && mvec_r[idx_r]);
  assign off_extra = extra_en_r && sc_r == 2'd0 && lm_v[sv_r] && l0hit_r;
  assign off_act   = sus_r ? ACT_MARK : (hold_v[idx_r] ? ACT_HOLD : ACT_STOP);

  logic [IW-1:0] act_idx;
  logic          occ_en, stop_en;
  logic [IW-1:0] occ_idx;

  assign act_idx = IW'(4'({2'b00, tgt_c_r} * 4'(VPC)) + 4'(k_r));
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    occ_en    = 1'b0;
    occ_idx   = idx_r;
    stop_en   = 1'b0;
    res_wr    = '0;
    flush     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (idx_r == IW'(NV - 1)) state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        if (ign) begin
          state_nxt = S_FLUSH;
        end else if (op_r) begin
          state_nxt = S_OFF;
        end else if (uni) begin
          state_nxt = ((un_r != 2'd0) || (ufn_r != 2'd0)) ? S_UOCC : S_USTEAL;
        end else if (is_mono) begin
          state_nxt = a_ev[vm] ? S_ACT : S_FLUSH;
        end else if (has_m_r || has_f_r) begin
          state_nxt = S_ACT;
        end else if (is_full) begin
          state_nxt = S_PSTEAL;
        end else begin
          state_nxt = sf_found ? S_ACT : S_FLUSH;
        end
      end
      S_ACT: begin
        if (am_r[k_r]) begin
          occ_en  = 1'b1;
          occ_idx = act_idx;
        end
        if (k_r == VW'(VPC - 1)) state_nxt = S_FLUSH;
      end
      S_UOCC: begin
        occ_en  = 1'b1;
        occ_idx = ol_r[j_r];
        // Voices that already play the note are retriggered and nothing is stolen.
        if (j_r == on_r - 2'd1) begin
          state_nxt = (on_r == 2'(WANT) || un_r != 2'd0) ? S_FLUSH : S_USTEAL;
        end
      end
      S_USTEAL: begin
        if (!fmask_r[uptr_r]) begin
          occ_en  = 1'b1;
          occ_idx = uptr_r;
          if (on_r == 2'(WANT - 1)) state_nxt = S_FLUSH;
        end
      end
      S_PSTEAL: begin
        if (ps_ok) begin
          state_nxt = S_ACT;
        end else if (ps_next == pstart_r || step_r == 4'(STEAL_LIMIT - 1)) begin
          state_nxt = S_FLUSH;
        end
      end
      S_OFF: begin
        if (off_hit || off_extra) begin
          res_wr.valid = 1'b1;
          res_wr.voice = 4'(idx_r);
          res_wr.act   = off_act;
          stop_en      = (off_act == ACT_STOP);
        end
        if (idx_r == IW'(NV - 1)) state_nxt = S_FLUSH;
      end
      S_FLUSH: begin
        flush     = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (!emit_busy) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    if (occ_en) begin
      res_wr.valid = 1'b1;
      res_wr.voice = 4'(occ_idx);
      res_wr.act   = ACT_TRIGGER;
    end
  end

  // Datapath registers without reset
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        op_r   <= in_opcode;
        ch_r   <= in_channel;
        note_r <= in_note;
        sus_r  <= in_sustain;
        c_ev_r <= chip_of_f(in_channel);
      end
      S_SCAN: begin
        mvec_r[idx_r] <= cur_match;
        if (!has_m_r && cur_match && scope && (is_full || cur_alw)) m_idx_r <= idx_r;
        if (!has_f_r && !cur_busy && cur_alw && scope) f_idx_r <= idx_r;
        if (cur_match && un_r < 2'(WANT)) ul_r[un_r] <= idx_r;
        if (!cur_busy && ufn_r < 2'(WANT)) uf_r[ufn_r] <= idx_r;
      end
      S_DECIDE: begin
        k_r <= '0;
        j_r <= 2'd0;
        if (op_r) begin
          am_r       <= am_f(vm);
          extra_en_r <= is_semi ? (c_ev_r == 2'd0) : ((is_full || uni) ? sus_r : 1'b0);
          l0hit_r    <= |(mvec_r[VPC-1:0] & lm_v);
        end else if (uni) begin
          for (int u = 0; u < UNISON_WIDTH; u++) ol_r[u] <= (un_r != 2'd0) ? ul_r[u] : uf_r[u];
        end else if (is_mono) begin
          tgt_c_r <= c_ev_r;
          am_r    <= am_f(vm);
        end else if (has_m_r || has_f_r) begin
          tgt_c_r <= 2'(tsel_q);
          am_r    <= am_f(VW'(tsel_r4));
        end else if (is_full) begin
          pstart_r <= pptr_r;
        end else begin
          tgt_c_r <= c_ev_r;
          am_r    <= am_f(sf_v);
        end
      end
      S_ACT: k_r <= k_r + VW'(1);
      S_UOCC: j_r <= j_r + 2'd1;
      S_PSTEAL: begin
        if (ps_ok) begin
          tgt_c_r <= 2'(ps_c4);
          am_r    <= am_f(VW'(ps_v4));
        end
      end
      default: ;
    endcase
    if (occ_en) begin
      vnote_r[occ_idx] <= note_r;
      owner_r[occ_idx] <= ch_r;
    end
  end

  // Control state, pointers and busy flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
      sc_r    <= '0;
      sv_r    <= '0;
      has_m_r <= 1'b0;
      has_f_r <= 1'b0;
      un_r    <= 2'd0;
      ufn_r   <= 2'd0;
      on_r    <= 2'd0;
      fmask_r <= '0;
      step_r  <= '0;
      pptr_r  <= '0;
      uptr_r  <= '0;
      for (int c = 0; c < CHIPS; c++) cptr_r[c] <= '0;
      for (int i = 0; i < NV; i++) busy_r[i] <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_IDLE: begin
          idx_r   <= '0;
          sc_r    <= '0;
          sv_r    <= '0;
          has_m_r <= 1'b0;
          has_f_r <= 1'b0;
          un_r    <= 2'd0;
          ufn_r   <= 2'd0;
          fmask_r <= '0;
        end
        S_SCAN, S_OFF: begin
          if (state_r == S_SCAN) begin
            if (!has_m_r && cur_match && scope && (is_full || cur_alw)) has_m_r <= 1'b1;
            if (!has_f_r && !cur_busy && cur_alw && scope) has_f_r <= 1'b1;
            if (cur_match && un_r < 2'(WANT)) un_r <= un_r + 2'd1;
            if (!cur_busy && ufn_r < 2'(WANT)) ufn_r <= ufn_r + 2'd1;
          end
          if (idx_r == IW'(NV - 1)) begin
            idx_r <= '0;
            sc_r  <= '0;
            sv_r  <= '0;
          end else begin
            idx_r <= idx_r + IW'(1);
            if (sv_r == VW'(VPC - 1)) begin
              sv_r <= '0;
              sc_r <= sc_r + 2'd1;
            end else begin
              sv_r <= sv_r + VW'(1);
            end
          end
        end
        S_DECIDE: begin
          step_r <= '0;
          on_r   <= (un_r != 2'd0) ? un_r : ufn_r;
          // Semi poly steal: the chip pointer moves past the chosen voice.
          if (!ign && !op_r && is_semi && !has_m_r && !has_f_r && sf_found) begin
            cptr_r[c_ev_r[CW-1:0]] <= (sf_v == VW'(VPC - 1)) ? '0 : sf_v + VW'(1);
          end
        end
        S_USTEAL: begin
          uptr_r <= (uptr_r == IW'(NV - 1)) ? '0 : uptr_r + IW'(1);
          if (!fmask_r[uptr_r]) on_r <= on_r + 2'd1;
        end
        S_PSTEAL: begin
          pptr_r <= ps_next;
          step_r <= step_r + 4'd1;
        end
        default: ;
      endcase
      if (occ_en) begin
        busy_r[occ_idx]  <= 1'b1;
        fmask_r[occ_idx] <= 1'b1;
      end
      if (stop_en) busy_r[idx_r] <= 1'b0;
    end
  end

endmodule

@@ rtl/poly_voice_allocator.sv @@
`timescale 1ns / 1ps
// Voice allocator for a bank of CHIPS x VOICES_PER_CHIP synthesizer voices.
// The input channel carries note-on and note-off events; each event yields
// one or more result beats on the output channel (voice index and action),
// the final one flagged by last. An event that touches no voice yields a
// single beat with action none.
// Configuration registers are written through the cfg channel, which is
// always ready; write them only while no event is in flight.
// Timing: in_ready is high only in the idle state. An accepted event is
// scanned over all NV voices (one voice a cycle through the shared compare
// unit) and decided in a decision state, then goes to the trigger states,
// to unison trigger and unison steal steps (up to three voices in all), to
// poly steal steps ahead of the trigger states (up to sixteen candidates),
// or to a release pass over all voices; then a flush state hands the list
// to the output, which sends one result beat per cycle while the receiver
// is ready, and in_ready returns once the list is drained.
// Results are held in a small list and sent through an output register; a
// stalled receiver holds the current beat and delays the next event.
// Reset (synchronous, active low) frees all voices, clears the steal
// pointers and loads the register defaults.
module poly_voice_allocator import pva_pkg::*; #(
  parameter int CHIPS           = CHIPS_DEF,
  parameter int VOICES_PER_CHIP = VPC_DEF,
  parameter int CHANNELS        = CHANNELS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  pva_in_if.sink    in_chan,
  pva_out_if.source out_chan,
  pva_cfg_if.sink   cfg_chan
);

  cfg_t    cfg_q;
  res_wr_t res_wr;
  logic    flush;
  logic    emit_busy;

  pva_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (cfg_chan.valid),
    .wr_ready (cfg_chan.ready),
    .wr_index (cfg_chan.index),
    .wr_data  (cfg_chan.data),
    .cfg_q    (cfg_q)
  );

  pva_core #(
    .CHIPS           (CHIPS),
    .VOICES_PER_CHIP (VOICES_PER_CHIP),
    .CHANNELS        (CHANNELS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_q      (cfg_q),
    .in_valid   (in_chan.valid),
    .in_ready   (in_chan.ready),
    .in_opcode  (in_chan.opcode),
    .in_channel (in_chan.channel),
    .in_note    (in_chan.note),
    .in_sustain (in_chan.sustain_held),
    .res_wr     (res_wr),
    .flush      (flush),
    .emit_busy  (emit_busy)
  );

  pva_emit u_emit (
    .clk             (clk),
    .rst_n           (rst_n),
    .res_wr          (res_wr),
    .flush           (flush),
    .busy            (emit_busy),
    .out_valid       (out_chan.valid),
    .out_ready       (out_chan.ready),
    .out_voice_index (out_chan.voice_index),
    .out_action      (out_chan.action),
    .out_last        (out_chan.last)
  );

endmodule
